[rtl/vsge_pkg.sv]
// ---------------------------------------------------------------------------
// Vehicle speed and gear estimator package
// Shared sequencer states, fixed constants and the gear constant table.
// ---------------------------------------------------------------------------
`default_nettype none

package vsge_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CHK,
		ST_DIV,
		ST_GATE,
		ST_GMUL,
		ST_GCMP,
		ST_DONE
	} vsge_state_t;

	typedef enum logic [1:0] {
		REG_MIN_PERIOD = 2'd0,
		REG_TIMEOUT    = 2'd1,
		REG_PPM        = 2'd2
	} vsge_reg_t;

	localparam logic [27:0] SPEED_NUM     = 28'd256000000;
	localparam logic [47:0] SAT_LIMIT     = 48'd1000000;
	localparam logic [15:0] RPM_MIN       = 16'd1500;
	localparam logic [7:0]  SPEED_MIN     = 8'd5;
	localparam logic [7:0]  SPEED_SAT     = 8'd255;
	localparam logic [2:0]  GEAR_NONE     = 3'd0;
	localparam logic [2:0]  GEAR_MAX      = 3'd6;
	localparam logic [15:0] MIN_PERIOD_RST = 16'd200;
	localparam logic [19:0] TIMEOUT_RST    = 20'd100000;
	localparam logic [15:0] PPM_RST        = 16'd4262;

	// Gear constants in Q4.8; gears past the sixth never match.
	function automatic logic [11:0] gear_k(input logic [2:0] g);
		logic [11:0] k;
		unique case (g)
			3'd0: k = 12'd3087;
			3'd1: k = 12'd2243;
			3'd2: k = 12'd1923;
			3'd3: k = 12'd1632;
			3'd4: k = 12'd1459;
			3'd5: k = 12'd1350;
			default: k = 12'd0;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

[rtl/vehicle_speed_and_gear_estimator.sv]
// ---------------------------------------------------------------------------
// Vehicle speed and gear estimator
// Debounces speed-sensor edges; a sample with a recent edge gets speed by a
// bit-serial multiply and divide and scans the gear table one gear at a time.
// ---------------------------------------------------------------------------
// An edge beat gives no result.
// A sample with no recent edge goes straight to done, giving speed zero.
// Other samples skip the divide when the product shows saturation, and skip
// the gear scan (a multiply and compare state per gear) when the gate fails.
// One item is in work at a time; a waiting result does not block new items.
// Reset is asynchronous and restores register defaults and clears the state.
`default_nettype none

module vehicle_speed_and_gear_estimator
	import vsge_pkg::*;
#(
	parameter int GEAR_COUNT = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        mode,
	input  wire logic [31:0] time_us,
	input  wire logic [15:0] rpm,
	input  wire logic        clutch,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       speed,
	output logic [2:0]       gear
);

	localparam logic [2:0] LAST_GEAR = 3'(GEAR_COUNT - 1);

	vsge_state_t state_q, state_d;

	logic [15:0] min_period_q;
	logic [19:0] timeout_q;
	logic [15:0] ppm_q;
	logic [31:0] last_edge_q;
	logic [31:0] period_q;

	logic [3:0]  cnt_q;
	logic [2:0]  g_q;
	logic        out_valid_q;

	logic [15:0] rpm_q;
	logic        clutch_q;
	logic [15:0] mpl_q;
	logic [47:0] acc_q;
	logic [55:0] ds_q;
	logic [27:0] rem_q;
	logic [7:0]  speed_q;
	logic [23:0] sp_ppm_q;
	logic [35:0] exp_q;
	logic [35:0] best_err_q;
	logic        have_q;
	logic [2:0]  best_q;
	logic [7:0]  out_speed_q;
	logic [2:0]  out_gear_q;

	logic        accept;
	logic [31:0] dt;
	logic        speed_zero;
	logic        div_ge;
	logic        gear_skip;
	logic [35:0] target;
	logic [35:0] err;
	logic [40:0] err25;
	logic [40:0] exp2;
	logic        match;
	logic        load_out;

	assign accept     = item_valid && !item_stall;
	assign dt         = time_us - last_edge_q;
	assign speed_zero = (period_q == 32'd0) || (dt > {12'd0, timeout_q});
	assign div_ge     = {28'd0, rem_q} >= ds_q;
	assign gear_skip  = clutch_q || (rpm_q < RPM_MIN) || (speed_q < SPEED_MIN);
	assign target     = {4'd0, rpm_q, 16'd0};
	assign err        = (target > exp_q) ? (target - exp_q) : (exp_q - target);
	assign err25      = {1'b0, err, 4'd0} + {2'b0, err, 3'd0} + {5'd0, err};
	assign exp2       = {4'd0, exp_q, 1'b0};
	assign match      = err25 < exp2;

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid && mode) begin
					state_d = speed_zero ? ST_DONE : ST_MUL;
				end
			end
			ST_MUL: begin
				if (cnt_q == 4'd15) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = (acc_q <= SAT_LIMIT) ? ST_GATE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == 4'd7) begin
					state_d = ST_GATE;
				end
			end
			ST_GATE: begin
				state_d = gear_skip ? ST_DONE : ST_GMUL;
			end
			ST_GMUL: begin
				state_d = ST_GCMP;
			end
			ST_GCMP: begin
				state_d = (g_q == LAST_GEAR) ? ST_DONE : ST_GMUL;
			end
			ST_DONE: begin
				if (!out_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			min_period_q <= MIN_PERIOD_RST;
			timeout_q    <= TIMEOUT_RST;
			ppm_q        <= PPM_RST;
			last_edge_q  <= 32'd0;
			period_q     <= 32'd0;
			cnt_q        <= 4'd0;
			g_q          <= 3'd0;
			have_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_PERIOD: min_period_q <= cfg_data[15:0];
					REG_TIMEOUT:    timeout_q    <= cfg_data;
					REG_PPM:        ppm_q        <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (accept && !mode && (dt >= {16'd0, min_period_q})) begin
				period_q    <= dt;
				last_edge_q <= time_us;
			end
			if (state_q == ST_MUL || state_q == ST_DIV) begin
				cnt_q <= (state_d == state_q) ? cnt_q + 4'd1 : 4'd0;
			end else begin
				cnt_q <= 4'd0;
			end
			if (state_q == ST_GATE) begin
				g_q    <= 3'd0;
				have_q <= 1'b0;
			end else if (state_q == ST_GCMP) begin
				g_q <= g_q + 3'd1;
				if (match && (!have_q || err < best_err_q)) begin
					have_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rpm_q    <= rpm;
				clutch_q <= clutch;
				mpl_q    <= ppm_q;
				acc_q    <= 48'd0;
				speed_q  <= 8'd0;
				best_q   <= GEAR_NONE;
			end
			ST_MUL: begin
				acc_q <= {acc_q[46:0], 1'b0} + (mpl_q[15] ? {16'd0, period_q} : 48'd0);
				mpl_q <= {mpl_q[14:0], 1'b0};
			end
			ST_CHK: begin
				ds_q    <= {1'b0, acc_q, 7'd0};
				rem_q   <= SPEED_NUM;
				speed_q <= SPEED_SAT;
			end
			ST_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - ds_q[27:0];
				end
				speed_q <= {speed_q[6:0], div_ge};
				ds_q    <= {1'b0, ds_q[55:1]};
			end
			ST_GATE: begin
				sp_ppm_q <= speed_q * ppm_q;
				best_q   <= GEAR_NONE;
			end
			ST_GMUL: begin
				exp_q <= sp_ppm_q * gear_k(g_q);
			end
			ST_GCMP: begin
				if (match && (!have_q || err < best_err_q)) begin
					best_err_q <= err;
					best_q     <= g_q + 3'd1;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					out_speed_q <= speed_q;
					out_gear_q  <= best_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign speed        = out_speed_q;
	assign gear         = out_gear_q;

endmodule

`default_nettype wire

[rtl/vsge_checker.sv]
// ---------------------------------------------------------------------------
// Vehicle speed and gear estimator port checker
// Watches the top-level ports for result ordering and plausibility.
// ---------------------------------------------------------------------------
`default_nettype none

module vsge_checker
	import vsge_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_valid,
	input wire logic       item_stall,
	input wire logic       result_valid,
	input wire logic       result_stall,
	input wire logic [7:0] speed,
	input wire logic [2:0] gear
);

	// A stalled result beat stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	// A result never appears in the cycle right after an input beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !$rose(result_valid))
		else $error("result appeared too early after an input beat");

	// A new result is loaded only while the input side is held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result loaded while idle");

	// A gear is reported only at a plausible speed and within the table.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && gear != GEAR_NONE |-> speed >= SPEED_MIN && gear <= GEAR_MAX)
		else $error("gear reported at an implausible speed");

endmodule

bind vehicle_speed_and_gear_estimator vsge_checker u_vsge_checker (.*);

`default_nettype wire

[verif/tb.sv]
// ---------------------------------------------------------------------------
// Vehicle speed and gear estimator testbench
// Drives pulse edges and sample requests through the valid/stall item port,
// keeps a bit-exact software copy of the debounce, speed and gear logic, and
// compares every result beat with the reading predicted for its sample.
// Directed cases cover the corners, then randomized phases run ride-like
// traffic under random register settings, sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module tb
	import vsge_pkg::*;
;

	localparam int GEAR_TOTAL = 6;
	localparam int LONG_HOLD = 600;
	localparam int SETTLE_CYCLES = 50;
	localparam int LIMIT_CYCLES = 600000;
	localparam int RANDOM_ITEMS = 480;
	localparam logic MODE_EDGE = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] speed;
		logic [2:0] gear;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [19:0] cfg_data;
	logic        item_valid;
	logic        item_stall;
	logic        mode;
	logic [31:0] time_us;
	logic [15:0] rpm;
	logic        clutch;
	logic        result_valid;
	logic        result_stall;
	logic [7:0]  speed;
	logic [2:0]  gear;

	logic [15:0] min_gap;
	logic [19:0] stale_limit;
	logic [15:0] ppm_q8;
	logic [31:0] edge_time_q;
	logic [31:0] period_q;

	reading_t pending_readings[$];
	int mismatches;
	int random_sent;
	int burst_left;
	bit steady;
	int hold_requests;
	int target_mph;

	vehicle_speed_and_gear_estimator #(
		.GEAR_COUNT(GEAR_TOTAL)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.mode(mode),
		.time_us(time_us),
		.rpm(rpm),
		.clutch(clutch),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.speed(speed),
		.gear(gear)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [63:0] gear_q8(input int g);
		case (g)
			0: return 64'd3087;
			1: return 64'd2243;
			2: return 64'd1923;
			3: return 64'd1632;
			4: return 64'd1459;
			5: return 64'd1350;
			default: return 64'd0;
		endcase
	endfunction

	function automatic logic [7:0] calc_speed(input logic [31:0] now);
		logic [31:0] elapsed;
		logic [63:0] div;
		logic [63:0] q;
		elapsed = now - edge_time_q;
		if (period_q == 32'd0 || elapsed > {12'd0, stale_limit})
			return 8'd0;
		div = 64'(period_q) * 64'(ppm_q8);
		if (div == 64'd0)
			return 8'd255;
		q = 64'd256000000 / div;
		return (q > 64'd255) ? 8'd255 : q[7:0];
	endfunction

	function automatic logic [2:0] calc_gear(input logic [7:0] spd, input logic [15:0] r,
			input logic c);
		logic [63:0] target;
		logic [63:0] expv;
		logic [63:0] err;
		logic [63:0] best_err;
		logic [2:0] best;
		bit have;
		target = 64'(r) << 16;
		best = 3'd0;
		best_err = 64'd0;
		have = 1'b0;
		if (c || r < 16'd1500 || spd < 8'd5)
			return 3'd0;
		for (int g = 0; g < GEAR_TOTAL && g < 8; g++) begin
			expv = 64'(spd) * 64'(ppm_q8) * gear_q8(g);
			err = (target > expv) ? target - expv : expv - target;
			if (err * 64'd25 < expv * 64'd2 && (!have || err < best_err)) begin
				have = 1'b1;
				best_err = err;
				best = 3'(g + 1);
			end
		end
		return best;
	endfunction

	// Engine speed that gear g implies at the speed seen at time now, scaled by pct.
	function automatic logic [15:0] rpm_near(input logic [31:0] now, input int g, input int pct);
		logic [63:0] e;
		e = (64'(calc_speed(now)) * 64'(ppm_q8) * gear_q8(g)) >> 16;
		e = e * 64'(pct) / 64'd100;
		return (e > 64'd65535) ? 16'hFFFF : e[15:0];
	endfunction

	task automatic pace();
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
		end
	endtask

	task automatic send_item(input logic m, input logic [31:0] t, input logic [15:0] r,
			input logic c);
		reading_t next_reading;
		logic [31:0] dt;
		item_valid <= 1'b1;
		mode <= m;
		time_us <= t;
		rpm <= r;
		clutch <= c;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (m == MODE_EDGE) begin
			dt = t - edge_time_q;
			if (dt >= {16'd0, min_gap}) begin
				period_q = dt;
				edge_time_q = t;
			end
		end else begin
			next_reading.speed = calc_speed(t);
			next_reading.gear = calc_gear(next_reading.speed, r, c);
			pending_readings.push_back(next_reading);
		end
		pace();
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [19:0] gap_val, input logic [19:0] stale_val,
			input logic [19:0] ppm_val);
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_PERIOD;
		cfg_data <= gap_val;
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= stale_val;
		@(posedge clk);
		cfg_index <= REG_PPM;
		cfg_data <= ppm_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		min_gap = gap_val[15:0];
		stale_limit = stale_val;
		ppm_q8 = ppm_val[15:0];
		@(posedge clk);
	endtask

	task automatic write_spare(input logic [19:0] data);
		cfg_we <= 1'b1;
		cfg_index <= REG_SPARE;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic ride_items(input int count);
		int roll;
		logic [63:0] per;
		logic [31:0] t;
		logic [15:0] r;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 11) == 0)
				target_mph = $urandom_range(1, 300);
			if (ppm_q8 == 16'd0) begin
				per = 64'($urandom_range(1, 5000));
			end else begin
				per = 64'd256000000 / (64'(target_mph) * 64'(ppm_q8));
				per = per + per * 64'($urandom_range(0, 6)) / 64'd100;
				if (per == 64'd0)
					per = 64'd1;
				if (per > 64'hFFFF_FFFF)
					per = 64'hFFFF_FFFF;
			end
			if (roll < 40) begin
				send_item(MODE_EDGE, edge_time_q + per[31:0], 16'($urandom), 1'($urandom));
			end else if (roll < 48) begin
				send_item(MODE_EDGE, edge_time_q + 32'($urandom_range(0, min_gap)), 16'($urandom),
					1'($urandom));
			end else if (roll < 88) begin
				t = edge_time_q + 32'($urandom_range(0, 2000));
				if ($urandom_range(0, 9) == 0)
					r = 16'($urandom);
				else
					r = rpm_near(t, $urandom_range(0, GEAR_TOTAL - 1), $urandom_range(85, 115));
				send_item(MODE_SAMPLE, t, r, $urandom_range(0, 9) == 0);
			end else if (roll < 92) begin
				t = edge_time_q + {12'd0, stale_limit} + 32'($urandom_range(0, 3));
				send_item(MODE_SAMPLE, t, rpm_near(t, 0, 100), 1'b0);
			end else begin
				send_item(1'($urandom), $urandom, 16'($urandom), 1'($urandom));
			end
			random_sent++;
		end
	endtask

	task automatic test_default_registers();
		send_item(MODE_SAMPLE, 32'd10, 16'd3000, 1'b0);
		send_item(MODE_EDGE, 32'd150, 16'hFFFF, 1'b1);
		send_item(MODE_EDGE, 32'd250, 16'd0, 1'b0);
		send_item(MODE_SAMPLE, 32'd300, 16'hFFFF, 1'b0);
		send_item(MODE_EDGE, 32'd2250, 16'd0, 1'b0);
		send_item(MODE_SAMPLE, 32'd2300, rpm_near(32'd2300, 0, 100), 1'b0);
		send_item(MODE_SAMPLE, 32'd2300, rpm_near(32'd2300, 0, 100), 1'b1);
		send_item(MODE_SAMPLE, 32'd2300, 16'd1499, 1'b0);
		send_item(MODE_SAMPLE, 32'd102250, rpm_near(32'd102250, 1, 100), 1'b0);
		send_item(MODE_SAMPLE, 32'd102251, rpm_near(32'd102250, 1, 100), 1'b0);
		send_item(MODE_EDGE, 32'hFFFF_FF00, 16'd0, 1'b0);
		send_item(MODE_EDGE, 32'h0000_0100, 16'd0, 1'b0);
		send_item(MODE_EDGE, 32'h0000_01C8, 16'd0, 1'b0);
		send_item(MODE_SAMPLE, 32'h0000_0200, 16'hFFFF, 1'b0);
	endtask

	task automatic test_gear_table();
		logic [31:0] t;
		send_item(MODE_EDGE, edge_time_q + 32'd512, 16'd0, 1'b0);
		t = edge_time_q + 32'd40;
		for (int g = 0; g < GEAR_TOTAL; g++)
			send_item(MODE_SAMPLE, t, rpm_near(t, g, 100), 1'b0);
		send_item(MODE_SAMPLE, t, rpm_near(t, 0, 92), 1'b0);
		send_item(MODE_SAMPLE, t, rpm_near(t, 0, 108), 1'b0);
	endtask

	task automatic test_register_extremes();
		logic [31:0] t0;
		drain();
		set_regs({4'hA, 16'd0}, 20'd0, {4'h5, 16'd0});
		write_spare(20'hFFFFF);
		t0 = edge_time_q + 32'd1000;
		send_item(MODE_EDGE, t0, 16'd0, 1'b0);
		send_item(MODE_EDGE, t0, 16'd0, 1'b0);
		send_item(MODE_SAMPLE, t0, 16'd3000, 1'b0);
		send_item(MODE_EDGE, t0 + 32'd1000, 16'd0, 1'b0);
		send_item(MODE_SAMPLE, t0 + 32'd1000, 16'd3000, 1'b0);
		send_item(MODE_SAMPLE, t0 + 32'd1001, 16'd3000, 1'b0);
		drain();
		set_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		send_item(MODE_EDGE, t0 + 32'd1000 + 32'd65534, 16'd0, 1'b0);
		send_item(MODE_EDGE, t0 + 32'd1000 + 32'd65535, 16'd0, 1'b0);
		send_item(MODE_SAMPLE, edge_time_q + 32'd1048575, 16'hFFFF, 1'b0);
		drain();
	endtask

	task automatic test_backpressure();
		set_regs(20'd200, 20'd100000, 20'd4262);
		steady = 1'b1;
		hold_requests++;
		ride_items(40);
		steady = 1'b0;
		drain();
	endtask

	task automatic test_random_traffic();
		logic [19:0] gap_val;
		logic [19:0] stale_val;
		logic [19:0] ppm_val;
		while (random_sent < RANDOM_ITEMS) begin
			drain();
			case ($urandom_range(0, 9))
				0: begin
					gap_val = {4'($urandom), 16'd0};
					stale_val = 20'd0;
					ppm_val = {4'($urandom), 16'd0};
				end
				1: begin
					gap_val = 20'hFFFFF;
					stale_val = 20'hFFFFF;
					ppm_val = 20'hFFFFF;
				end
				2: begin
					gap_val = 20'd0;
					stale_val = 20'hFFFFF;
					ppm_val = 20'd1;
				end
				default: begin
					gap_val = {4'($urandom), 16'($urandom_range(0, 300))};
					stale_val = 20'($urandom_range(50000, 1048575));
					ppm_val = {4'($urandom), 16'($urandom_range(1000, 20000))};
				end
			endcase
			set_regs(gap_val, stale_val, ppm_val);
			ride_items($urandom_range(30, 80));
		end
	endtask

	// Each accepted result beat is matched against the oldest predicted reading.
	always @(posedge clk) begin : check_beat
		reading_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_readings.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: speed %0d gear %0d", speed, gear);
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				if (speed !== want.speed || gear !== want.gear) begin
					if (mismatches < 10)
						$display("mismatch: expected speed %0d gear %0d, got speed %0d gear %0d",
							want.speed, want.gear, speed, gear);
					mismatches++;
				end
			end
		end
	end

	initial begin : receiver
		int seg_len;
		int kind;
		logic [15:0] mask;
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		result_stall <= 1'b0;
		forever begin
			seg_len = $urandom_range(20, 200);
			kind = $urandom_range(0, 3);
			mask = 16'($urandom);
			for (int i = 0; i < seg_len; i++) begin
				@(posedge clk);
				if (holds_served != hold_requests) begin
					holds_served = hold_requests;
					hold_left = LONG_HOLD;
				end
				if (hold_left > 0) begin
					result_stall <= 1'b1;
					hold_left--;
				end else begin
					case (kind)
						0: result_stall <= 1'b0;
						1: result_stall <= ($urandom_range(0, 3) == 0);
						2: result_stall <= ($urandom_range(0, 3) != 0);
						default: result_stall <= mask[i % 16];
					endcase
				end
			end
		end
	end

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_MIN_PERIOD;
		cfg_data <= 20'd0;
		item_valid <= 1'b0;
		mode <= MODE_EDGE;
		time_us <= 32'd0;
		rpm <= 16'd0;
		clutch <= 1'b0;
		mismatches = 0;
		random_sent = 0;
		burst_left = 0;
		steady = 1'b0;
		hold_requests = 0;
		target_mph = 30;
		min_gap = MIN_PERIOD_RST;
		stale_limit = TIMEOUT_RST;
		ppm_q8 = PPM_RST;
		edge_time_q = 32'd0;
		period_q = 32'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_registers();
		test_gear_table();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();
		drain();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
